/* src/midi_track_event_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// MIDI track event parser assertion macros
// Shared concurrent assertion forms for the parser blocks.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define MTEP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtep assertion failed: same-cycle implication");

// Check that a condition implies another in the following cycle
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtep assertion failed: next-cycle implication");

`endif

/* src/mtep_pkg.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Result record layout, record kind and error codes shared by all parts.
// ----------------------------------------------------------------------------
package mtep_pkg;

   // Record kinds
   localparam logic [2:0] KIND_CHANNEL = 3'd0;
   localparam logic [2:0] KIND_SYSEX_F0 = 3'd1;
   localparam logic [2:0] KIND_SYSEX_F7 = 3'd2;
   localparam logic [2:0] KIND_META = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD = 3'd4;

   // Error codes
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_NO_RUNNING = 2'd1;
   localparam logic [1:0] ERR_UNDEFINED = 2'd2;

   // Special type bytes
   localparam logic [7:0] TYPE_SYSEX_START = 8'hF0;
   localparam logic [7:0] TYPE_SYSEX_CONT = 8'hF7;
   localparam logic [7:0] TYPE_META = 8'hFF;
   localparam logic [7:0] LAST_CHANNEL_STATUS = 8'hEF;

   // Result queue depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   // One result record
   typedef struct packed {
      logic [2:0] record_kind;
      logic [31:0] delta_ticks;
      logic [7:0] status_byte;
      logic [7:0] meta_type;
      logic [31:0] payload_length;
      logic [6:0] first_data;
      logic [6:0] second_data;
      logic [7:0] payload_byte;
      logic event_last;
      logic [1:0] error_code;
   } record_type;

   // Queue fill status seen by the front and back parts
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

/* src/mtep_front.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser front end
// Accepts one track byte per cycle while the queue is not full, tracks the
// event phase and pushes finished result records into the queue.
// ----------------------------------------------------------------------------
module mtep_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    byte_valid,
   input  logic [7:0]              stream_byte,
   output logic                    byte_ready,
   input  mtep_pkg::queue_stat_type q_stat,
   output logic                    push,
   output mtep_pkg::record_type    push_rec
);
   import mtep_pkg::*;

   typedef enum logic [2:0] {
      PH_DELTA    = 3'd0,
      PH_TYPE     = 3'd1,
      PH_METATYPE = 3'd2,
      PH_LENGTH   = 3'd3,
      PH_PAYLOAD  = 3'd4,
      PH_DATA1    = 3'd5,
      PH_DATA2    = 3'd6
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [31:0] delta_ff, delta_in;
   logic [7:0] running_ff, running_in;
   logic [7:0] status_ff, status_in;
   logic [7:0] meta_ff, meta_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] remain_ff, remain_in;
   logic [6:0] held_ff, held_in;

   logic accept;
   logic [31:0] length_next;
   logic [31:0] remain_next;
   logic [2:0] header_kind;

   // One data byte for program change and channel pressure
   function automatic logic one_data(input logic [7:0] status);
      return (status[7:4] == 4'hC) || (status[7:4] == 4'hD);
   endfunction

   assign byte_ready = !q_stat.full;
   assign accept = byte_valid && byte_ready;
   assign length_next = {length_ff[24:0], stream_byte[6:0]};
   assign remain_next = remain_ff - 32'd1;

   always_comb begin
      priority if (status_ff == TYPE_SYSEX_START) begin
         header_kind = KIND_SYSEX_F0;
      end else if (status_ff == TYPE_SYSEX_CONT) begin
         header_kind = KIND_SYSEX_F7;
      end else begin
         header_kind = KIND_META;
      end
   end

   // Decode the byte and build the next state and the record
   always_comb begin
      logic end_evt;
      end_evt = 1'b0;
      phase_in = phase_ff;
      delta_in = delta_ff;
      running_in = running_ff;
      status_in = status_ff;
      meta_in = meta_ff;
      length_in = length_ff;
      remain_in = remain_ff;
      held_in = held_ff;
      push = 1'b0;
      push_rec = '0;
      push_rec.delta_ticks = delta_ff;
      push_rec.event_last = 1'b1;

      if (accept) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (stream_byte == TYPE_SYSEX_START || stream_byte == TYPE_SYSEX_CONT) begin
                  status_in = stream_byte;
                  meta_in = 8'd0;
                  length_in = 32'd0;
                  phase_in = PH_LENGTH;
               end else if (stream_byte == TYPE_META) begin
                  status_in = stream_byte;
                  phase_in = PH_METATYPE;
               end else if (!stream_byte[7]) begin
                  if (running_ff == 8'd0) begin
                     // Data byte with no running status
                     push = 1'b1;
                     push_rec.record_kind = KIND_CHANNEL;
                     push_rec.error_code = ERR_NO_RUNNING;
                     end_evt = 1'b1;
                  end else begin
                     status_in = running_ff;
                     if (one_data(running_ff)) begin
                        push = 1'b1;
                        push_rec.record_kind = KIND_CHANNEL;
                        push_rec.status_byte = running_ff;
                        push_rec.first_data = stream_byte[6:0];
                        end_evt = 1'b1;
                     end else begin
                        held_in = stream_byte[6:0];
                        phase_in = PH_DATA2;
                     end
                  end
               end else if (stream_byte <= LAST_CHANNEL_STATUS) begin
                  running_in = stream_byte;
                  status_in = stream_byte;
                  phase_in = PH_DATA1;
               end else begin
                  // Undefined status
                  push = 1'b1;
                  push_rec.record_kind = KIND_CHANNEL;
                  push_rec.status_byte = stream_byte;
                  push_rec.error_code = ERR_UNDEFINED;
                  end_evt = 1'b1;
               end
            end
            PH_METATYPE: begin
               meta_in = stream_byte;
               length_in = 32'd0;
               phase_in = PH_LENGTH;
            end
            PH_LENGTH: begin
               length_in = length_next;
               if (!stream_byte[7]) begin
                  push = 1'b1;
                  push_rec.record_kind = header_kind;
                  push_rec.status_byte = status_ff;
                  push_rec.meta_type = meta_ff;
                  push_rec.payload_length = length_next;
                  if (length_next == 32'd0) begin
                     end_evt = 1'b1;
                  end else begin
                     push_rec.event_last = 1'b0;
                     remain_in = length_next;
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               push = 1'b1;
               push_rec.record_kind = KIND_PAYLOAD;
               push_rec.status_byte = status_ff;
               push_rec.meta_type = meta_ff;
               push_rec.payload_length = length_ff;
               push_rec.payload_byte = stream_byte;
               push_rec.event_last = (remain_next == 32'd0);
               if (remain_next == 32'd0) begin
                  end_evt = 1'b1;
               end else begin
                  remain_in = remain_next;
               end
            end
            PH_DATA1: begin
               if (one_data(status_ff)) begin
                  push = 1'b1;
                  push_rec.record_kind = KIND_CHANNEL;
                  push_rec.status_byte = status_ff;
                  push_rec.first_data = stream_byte[6:0];
                  end_evt = 1'b1;
               end else begin
                  held_in = stream_byte[6:0];
                  phase_in = PH_DATA2;
               end
            end
            PH_DATA2: begin
               push = 1'b1;
               push_rec.record_kind = KIND_CHANNEL;
               push_rec.status_byte = status_ff;
               push_rec.first_data = held_ff;
               push_rec.second_data = stream_byte[6:0];
               end_evt = 1'b1;
            end
            default: begin
               // Shift in one delta time group
               delta_in = {delta_ff[24:0], stream_byte[6:0]};
               phase_in = stream_byte[7] ? PH_DELTA : PH_TYPE;
            end
         endcase

         // Clear per-event state
         if (end_evt) begin
            phase_in = PH_DELTA;
            delta_in = 32'd0;
            length_in = 32'd0;
            remain_in = 32'd0;
            meta_in = 8'd0;
            held_in = 7'd0;
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA;
         delta_ff <= '0;
         running_ff <= '0;
         status_ff <= '0;
         meta_ff <= '0;
         length_ff <= '0;
         remain_ff <= '0;
         held_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         delta_ff <= delta_in;
         running_ff <= running_in;
         status_ff <= status_in;
         meta_ff <= meta_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
         held_ff <= held_in;
      end
   end

endmodule

/* src/mtep_queue.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser result queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
module mtep_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  mtep_pkg::record_type     push_rec,
   input  logic                     pop,
   output mtep_pkg::record_type     pop_rec,
   output mtep_pkg::queue_stat_type q_stat
);
   import mtep_pkg::*;

   record_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0] count_ff, count_in;

   assign q_stat.full = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_rec = entry_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed record
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

/* src/mtep_back.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser back end
// Pops records from the queue into the output register and drives the
// result stream.
// ----------------------------------------------------------------------------
module mtep_back (
   input  logic                     clock,
   input  logic                     reset,
   input  mtep_pkg::queue_stat_type q_stat,
   input  mtep_pkg::record_type     pop_rec,
   output logic                     pop,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mtep_pkg::record_type     out_rec
);
   import mtep_pkg::*;

   logic valid_ff, valid_in;
   record_type rec_ff, rec_in;

   // Load when the register is empty or being drained
   assign pop = !q_stat.empty && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      rec_in = rec_ff;
      if (pop) begin
         valid_in = 1'b1;
         rec_in = pop_rec;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign out_valid = valid_ff;
   assign out_rec = rec_ff;

endmodule

/* src/midi_track_event_parser_unit.sv */
// ----------------------------------------------------------------------------
// MIDI track event parser unit
// Parses standard MIDI file track events one byte at a time and emits
// channel, sysex, meta header and payload records.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// req_      in   tdata: stream_byte
// rsp_      out  tdata: event fields, tuser: kind and error, tlast: event end
//
// One byte is accepted per cycle while the result queue is not full; each
// byte takes a single shift, compare and counter update, and its result
// passes through the result queue and the output register to rsp_.
// Reset is synchronous and clears the parser, the queue and the output.
// req_tready drops only while the four-entry result queue is full.
// ----------------------------------------------------------------------------
module midi_track_event_parser_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] stream_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] delta_ticks, [39:32] status_byte, [47:40] meta_type,
   // [79:48] payload_length, [86:80] first_data, [93:87] second_data,
   // [101:94] payload_byte, [103:102] zero
   output logic [103:0] rsp_tdata,
   output logic [4:0]   rsp_tuser,   // [2:0] record_kind, [4:3] error_code
   output logic         rsp_tlast    // event_last
);
   import mtep_pkg::*;

   `include "midi_track_event_parser_unit_macros.svh"

   queue_stat_type q_stat;
   logic push;
   logic pop;
   record_type push_rec;
   record_type pop_rec;
   record_type out_rec;

   mtep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .stream_byte (req_tdata),
      .byte_ready  (req_tready),
      .q_stat      (q_stat),
      .push        (push),
      .push_rec    (push_rec)
   );

   mtep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_stat   (q_stat)
   );

   mtep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_rec   (pop_rec),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rec   (out_rec)
   );

   // Pack the result transaction
   assign rsp_tdata = {2'b00,
                       out_rec.payload_byte,
                       out_rec.second_data,
                       out_rec.first_data,
                       out_rec.payload_length,
                       out_rec.meta_type,
                       out_rec.status_byte,
                       out_rec.delta_ticks};
   assign rsp_tuser = {out_rec.error_code, out_rec.record_kind};
   assign rsp_tlast = out_rec.event_last;

   // Never push into a full queue
   `MTEP_ASSERT_IMPLY(a_no_overflow, clock, reset, push, !q_stat.full)
   // Input stalls only on a full queue
   `MTEP_ASSERT_IMPLY(a_stall_full, clock, reset, !req_tready, q_stat.full)
   // Error records always close their event
   `MTEP_ASSERT_IMPLY(a_err_last, clock, reset, rsp_tvalid && (rsp_tuser[4:3] != ERR_NONE),
      rsp_tlast)
   // A pending record in the queue reaches the output register
   `MTEP_ASSERT_NEXT(a_drain, clock, reset, !q_stat.empty && !rsp_tvalid, rsp_tvalid)

endmodule
